// ----- sv/kpi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpi_pkg
// shared types, constants and packing helpers for the keyframe pose core
// ----------------------------------------------------------------------------
package kpi_pkg;

    localparam int KPI_MAX_KEYS  = 16;
    localparam int KPI_FRAC_BITS = 16;
    localparam int FRAME_W       = 16;
    localparam int VAL_W         = 32;
    localparam int NUM_VALS      = 5;
    localparam int IDX_W         = 4;
    localparam int CNT_CFG_W     = 5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [NUM_VALS-1:0][VAL_W-1:0] kpi_vals_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        kpi_vals_t          vals;
    } kpi_entry_t;

    typedef struct packed {
        logic                     cmd;
        logic [IDX_W-1:0]         entry_index;
        logic [FRAME_W-1:0]       frame_number;
        logic signed [VAL_W-1:0]  in_pos_x;
        logic signed [VAL_W-1:0]  in_pos_y;
        logic signed [VAL_W-1:0]  in_pos_z;
        logic signed [VAL_W-1:0]  in_pitch;
        logic signed [VAL_W-1:0]  in_yaw;
    } kpi_req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  out_pos_x;
        logic signed [VAL_W-1:0]  out_pos_y;
        logic signed [VAL_W-1:0]  out_pos_z;
        logic signed [VAL_W-1:0]  out_pitch;
        logic signed [VAL_W-1:0]  out_yaw;
        logic                     table_empty;
    } kpi_rsp_t;

    typedef struct packed {
        logic               start;
        logic [FRAME_W-1:0] num;
        logic [FRAME_W-1:0] den;
    } kpi_div_req_t;

    function automatic kpi_entry_t req_to_entry(input kpi_req_t r);
        kpi_entry_t e;
        e.frame   = r.frame_number;
        e.vals[0] = r.in_pos_x;
        e.vals[1] = r.in_pos_y;
        e.vals[2] = r.in_pos_z;
        e.vals[3] = r.in_pitch;
        e.vals[4] = r.in_yaw;
        return e;
    endfunction

    function automatic kpi_rsp_t vals_to_rsp(input kpi_vals_t v, input logic empty);
        kpi_rsp_t r;
        r.out_pos_x   = v[0];
        r.out_pos_y   = v[1];
        r.out_pos_z   = v[2];
        r.out_pitch   = v[3];
        r.out_yaw     = v[4];
        r.table_empty = empty;
        return r;
    endfunction

endpackage

// ----- sv/kpi_key_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpi_key_mem
// keyframe table, one write port and one registered read port
// ----------------------------------------------------------------------------
module kpi_key_mem
    import kpi_pkg::*;
#(
    parameter int DEPTH = KPI_MAX_KEYS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  kpi_entry_t               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output kpi_entry_t               rdata
);

    kpi_entry_t mem [DEPTH];
    kpi_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/kpi_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpi_div
// restoring divider, one quotient bit per cycle, gives (num << frac) / den
// ----------------------------------------------------------------------------
module kpi_div
    import kpi_pkg::*;
#(
    parameter int FRAC_BITS = KPI_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kpi_div_req_t       req,
    output logic               done,
    output logic [FRAC_BITS:0] quot
);

    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    logic [FRAME_W:0]     rem_reg, rem_next;
    logic [FRAME_W-1:0]   den_reg;
    logic [FRAC_BITS:0]   quot_reg, quot_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [FRAME_W+1:0]   trial;
    logic                 fits;
    logic [FRAME_W:0]     rem_kept;

    // trial subtract, keep the difference when it does not borrow
    always_comb
    begin
        trial     = {1'b0, rem_reg} - {2'b00, den_reg};
        fits      = ~trial[FRAME_W+1];
        rem_kept  = fits ? trial[FRAME_W:0] : rem_reg;
        rem_next  = {rem_kept[FRAME_W-1:0], 1'b0};
        quot_next = {quot_reg[FRAC_BITS-1:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(FRAC_BITS + 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= {1'b0, req.num};
            den_reg <= req.den;
        end
        else if (run_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- sv/kpi_lerp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpi_lerp
// three-stage subtract, multiply, shift-add pipe shared by the five offsets
// ----------------------------------------------------------------------------
module kpi_lerp
    import kpi_pkg::*;
#(
    parameter int FRAC_BITS = KPI_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  kpi_vals_t          a,
    input  kpi_vals_t          b,
    input  logic [FRAC_BITS:0] t,
    output logic               done,
    output kpi_vals_t          result
);

    localparam int STEP_W = $clog2(NUM_VALS + 2);
    localparam int SEL_W  = $clog2(NUM_VALS);
    localparam int PROD_W = VAL_W + FRAC_BITS + 3;

    logic [STEP_W-1:0]        step_reg;
    logic                     run_reg;
    logic                     done_reg;
    logic                     s1_en, s2_en, s3_en;
    logic [SEL_W-1:0]         k1, k3;
    logic signed [VAL_W:0]    diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] shifted;
    kpi_vals_t                res_reg;

    always_comb
    begin
        s1_en   = run_reg && (step_reg < STEP_W'(NUM_VALS));
        s2_en   = run_reg && (step_reg >= STEP_W'(1)) && (step_reg <= STEP_W'(NUM_VALS));
        s3_en   = run_reg && (step_reg >= STEP_W'(2));
        k1      = SEL_W'(step_reg);
        k3      = SEL_W'(step_reg - STEP_W'(2));
        shifted = prod_reg >>> FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                if (step_reg == STEP_W'(NUM_VALS + 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            diff_reg <= $signed({b[k1][VAL_W-1], b[k1]}) - $signed({a[k1][VAL_W-1], a[k1]});
        end
        if (s2_en)
        begin
            prod_reg <= diff_reg * $signed({1'b0, t});
        end
        if (s3_en)
        begin
            res_reg[k3] <= a[k3] + shifted[VAL_W-1:0];
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- sv/keyframe_pose_interpolator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_pose_interpolator_core
// keyframe table with piecewise linear pose lookup by frame number
// ----------------------------------------------------------------------------
// keyframe write: taken in the accept cycle, no result, busy stays low
// empty table query: done in the cycle after accept
// clamped query: done after reading the last and then the first entry
// interior query: those two reads, a segment scan, the divide, then the blend
// one request at a time (single table read port, shared divider); done cannot be stalled
// reset clears control and keyframe_count; table contents are undefined until written
module keyframe_pose_interpolator_core
    import kpi_pkg::*;
#(
    parameter int MAX_KEYS  = KPI_MAX_KEYS,
    parameter int FRAC_BITS = KPI_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 start,
    output logic                 busy,
    input  kpi_req_t             req,
    // result strobe
    output logic                 done,
    output kpi_rsp_t             rsp,
    // keyframe_count register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_CFG_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_KEYS);
    localparam int N_W    = ($clog2(MAX_KEYS + 1) > CNT_CFG_W) ?
                            $clog2(MAX_KEYS + 1) : CNT_CFG_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LAST  = 3'd1;  // last entry arriving
    localparam logic [2:0] S_FIRST = 3'd2;  // first entry arriving
    localparam logic [2:0] S_SCAN  = 3'd3;  // walking segments
    localparam logic [2:0] S_DIV   = 3'd4;  // waiting on t
    localparam logic [2:0] S_LERP  = 3'd5;  // blending offsets

    logic [2:0]           state_reg, state_next;
    logic [CNT_CFG_W-1:0] count_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic                 ge_last_reg, ge_last_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    kpi_entry_t           a_reg, a_next;
    kpi_entry_t           b_reg, b_next;
    kpi_rsp_t             rsp_reg, rsp_next;
    logic                 done_reg, done_next;

    logic [N_W-1:0]       count_w;
    logic [N_W-1:0]       num_keys;
    logic [ADDR_W-1:0]    last_addr;
    logic                 accept;
    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;
    kpi_entry_t           rd_entry;
    kpi_div_req_t         div_req;
    logic                 div_done;
    logic [FRAC_BITS:0]   div_quot;
    logic                 lerp_start;
    logic                 lerp_done;
    kpi_vals_t            lerp_vals;
    logic                 in_seg;

    // count above the table size saturates
    always_comb
    begin
        count_w   = N_W'(count_reg);
        num_keys  = (count_w > N_W'(MAX_KEYS)) ? N_W'(MAX_KEYS) : count_w;
        last_addr = ADDR_W'(num_keys - N_W'(1));
    end

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // slots beyond the table are dropped
    assign mem_we = accept && (req.cmd == CMD_WRITE) && (32'(req.entry_index) < MAX_KEYS);

    // frame inside the segment between the held entry and the one just read
    assign in_seg = (frame_reg >= a_reg.frame) && (frame_reg <= rd_entry.frame);

    kpi_key_mem #(
        .DEPTH (MAX_KEYS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ADDR_W'(req.entry_index)),
        .wdata (req_to_entry(req)),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_entry)
    );

    kpi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    kpi_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lerp_start),
        .a      (a_reg.vals),
        .b      (b_reg.vals),
        .t      (div_quot),
        .done   (lerp_done),
        .result (lerp_vals)
    );

    // sequencer: read last, read first, walk segments one read per cycle, then divide and blend
    always_comb
    begin
        state_next    = state_reg;
        ge_last_next  = ge_last_reg;
        idx_next      = idx_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        rsp_next      = rsp_reg;
        done_next     = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        div_req.start = 1'b0;
        div_req.num   = frame_reg - a_reg.frame;
        div_req.den   = rd_entry.frame - a_reg.frame;
        lerp_start    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.cmd == CMD_QUERY))
                begin
                    if (num_keys == '0)
                    begin
                        // empty table gives a zero pose
                        rsp_next  = vals_to_rsp('0, 1'b1);
                        done_next = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = last_addr;
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST:
            begin
                b_next       = rd_entry;
                ge_last_next = (frame_reg >= rd_entry.frame);
                mem_re       = 1'b1;
                mem_raddr    = '0;
                state_next   = S_FIRST;
            end
            S_FIRST:
            begin
                a_next = rd_entry;
                if (frame_reg <= rd_entry.frame)
                begin
                    // at or before the first keyframe
                    rsp_next   = vals_to_rsp(rd_entry.vals, 1'b0);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (ge_last_reg)
                begin
                    // at or past the last keyframe
                    rsp_next   = vals_to_rsp(b_reg.vals, 1'b0);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = ADDR_W'(1);
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (in_seg)
                begin
                    if (a_reg.frame == rd_entry.frame)
                    begin
                        // zero-length segment returns its start
                        rsp_next   = vals_to_rsp(a_reg.vals, 1'b0);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        b_next        = rd_entry;
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else if (idx_reg == last_addr)
                begin
                    // no enclosing segment, fall back to the last entry
                    rsp_next   = vals_to_rsp(rd_entry.vals, 1'b0);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    a_next    = rd_entry;
                    idx_next  = idx_reg + ADDR_W'(1);
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + ADDR_W'(1);
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    lerp_start = 1'b1;
                    state_next = S_LERP;
                end
            end
            S_LERP:
            begin
                if (lerp_done)
                begin
                    rsp_next   = vals_to_rsp(lerp_vals, 1'b0);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_reg <= req.frame_number;
        end
        ge_last_reg <= ge_last_next;
        idx_reg     <= idx_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        rsp_reg     <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // result strobe only follows a finished request
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE) && ($past(state_reg) != S_DIV))
        else $error("result strobe outside idle");

    // empty flag always comes with a zero pose
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.table_empty) |->
            (rsp_reg.out_pos_x == 0) && (rsp_reg.out_pos_y == 0) &&
            (rsp_reg.out_pos_z == 0) && (rsp_reg.out_pitch == 0) &&
            (rsp_reg.out_yaw == 0))
        else $error("empty result with nonzero pose");

    // divider finishes only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside wait state");

    // blend finishes only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        lerp_done |-> (state_reg == S_LERP))
        else $error("blend done outside wait state");

endmodule
